// ===== rtl/core/cke_pkg.sv =====
// shared types, constants and helpers of the canonical k-mer sketch extractor
package cke_pkg;

  localparam int HK_W        = 5;
  localparam int SUBK_W      = 2;
  localparam int RL_W        = 5;
  localparam int DIM_W       = 13;
  localparam int QUAL_W      = 8;
  localparam int CB_W        = 6;
  localparam int BYTE_W      = 8;
  localparam int TIDX_W      = 12;
  localparam int TVAL_W      = 12;
  localparam int WIN_W       = 64;
  localparam int RUN_W       = 6;
  localparam int KEY_W       = 64;
  localparam int HALF_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_HALF_K  = 16;

  localparam int DEF_MAX_HALF_SUBK = 3;
  localparam int DEF_TABLE_DEPTH   = 4096;

  localparam logic [BYTE_W-1:0] CH_HEADER = 8'h3e;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;

  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_K         = 3'd0,
    REG_HALF_SUBK      = 3'd1,
    REG_REDUCE_LEVEL   = 3'd2,
    REG_DIM_FLOOR      = 3'd3,
    REG_DIM_END        = 3'd4,
    REG_MIN_QUALITY    = 3'd5,
    REG_COMPONENT_BITS = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [HK_W-1:0]   half_k;
    logic [SUBK_W-1:0] half_subk;
    logic [RL_W-1:0]   reduce_level;
    logic [DIM_W-1:0]  dim_floor;
    logic [DIM_W-1:0]  dim_end;
    logic [QUAL_W-1:0] min_quality;
    logic [CB_W-1:0]   component_bits;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    half_k:         5'd10,
    half_subk:      2'd3,
    reduce_level:   5'd3,
    dim_floor:      13'd0,
    dim_end:        13'd4096,
    min_quality:    8'd0,
    component_bits: 6'd0
  };

  typedef struct packed {
    logic              is_write;
    logic [WIN_W-1:0]  fwd;
    logic [WIN_W-1:0]  rev;
    logic [HK_W-1:0]   hk;
    logic [TIDX_W-1:0] tidx;
    logic [TVAL_W-1:0] tval;
  } q_entry_t;

  typedef struct packed {
    logic ok;
    logic [1:0] code;
  } base_t;

  function automatic base_t base_code(input logic [BYTE_W-1:0] ch);
    base_t r;
    r = '{ok: 1'b1, code: 2'd0};
    case (ch)
      8'h41, 8'h61: r.code = 2'd0;
      8'h43, 8'h63: r.code = 2'd1;
      8'h47, 8'h67: r.code = 2'd2;
      8'h54, 8'h74: r.code = 2'd3;
      default:      r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/cke_front.sv =====
// front end: byte classification, run counting and rolling k-mer windows
module cke_front (
  input  logic                         clk,
  input  logic                         rst,
  input  cke_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic [cke_pkg::BYTE_W-1:0]   seq_byte,
  input  logic [cke_pkg::QUAL_W-1:0]   quality,
  input  logic                         read_start,
  input  logic [cke_pkg::TIDX_W-1:0]   table_index,
  input  logic [cke_pkg::TVAL_W-1:0]   table_value,
  input  logic                         q_full,
  output logic                         push,
  output cke_pkg::q_entry_t            entry
);
  import cke_pkg::*;

  logic [WIN_W-1:0] fwd, fwd_next;
  logic [WIN_W-1:0] rev, rev_next;
  logic [RUN_W-1:0] base_run, base_run_next;
  logic             in_header, in_header_next;

  logic             accept;
  logic [HK_W-1:0]  hk;
  logic [6:0]       hk4;
  logic [WIN_W-1:0] mask;
  logic [RUN_W-1:0] run_start, run_inc;
  base_t            base;

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;
  assign base     = base_code(seq_byte);

  always_comb begin
    if (cfg.half_k == '0) begin
      hk = HK_W'(1);
    end else if (cfg.half_k > HK_W'(MAX_HALF_K)) begin
      hk = HK_W'(MAX_HALF_K);
    end else begin
      hk = cfg.half_k;
    end
    hk4 = {hk, 2'b00};
    for (int i = 0; i < WIN_W; i++) begin
      mask[i] = 7'(i) < hk4;
    end
  end

  always_comb begin
    fwd_next       = fwd;
    rev_next       = rev;
    base_run_next  = base_run;
    in_header_next = in_header;
    push           = 1'b0;
    run_start      = read_start ? RUN_W'(1) : base_run;
    run_inc        = (run_start < RUN_MAX) ? run_start + RUN_W'(1) : run_start;
    if (accept) begin
      if (action) begin
        push = 1'b1;
      end else if (in_header) begin
        base_run_next = run_start;
        if (seq_byte == CH_LF) begin
          in_header_next = 1'b0;
        end
      end else if (seq_byte == CH_LF || seq_byte == CH_CR) begin
        base_run_next = run_start;
      end else if (seq_byte == CH_HEADER) begin
        in_header_next = 1'b1;
        base_run_next  = RUN_W'(1);
      end else if (!base.ok || quality < cfg.min_quality) begin
        base_run_next = RUN_W'(1);
      end else begin
        fwd_next      = ((fwd << 2) | WIN_W'(base.code)) & mask;
        rev_next      = ((rev >> 2) + (WIN_W'(base.code ^ 2'd3) << (hk4 - 7'd2))) & mask;
        base_run_next = run_inc;
        push          = run_inc > {hk, 1'b0};
      end
    end
  end

  always_comb begin
    entry.is_write = action;
    entry.fwd      = fwd_next;
    entry.rev      = rev_next;
    entry.hk       = hk;
    entry.tidx     = table_index;
    entry.tval     = table_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd       <= '0;
      rev       <= '0;
      base_run  <= RUN_W'(1);
      in_header <= 1'b0;
    end else begin
      fwd       <= fwd_next;
      rev       <= rev_next;
      base_run  <= base_run_next;
      in_header <= in_header_next;
    end
  end

endmodule

// ===== rtl/core/cke_queue.sv =====
// short queue between the front end and the back end
module cke_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cke_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output cke_pkg::q_entry_t head
);
  import cke_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  q_entry_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

// ===== rtl/core/cke_back.sv =====
// back end: shuffle table, dimension filter, key packing and output register
module cke_back #(
  parameter int MAX_HALF_SUBK = cke_pkg::DEF_MAX_HALF_SUBK,
  parameter int TABLE_DEPTH   = cke_pkg::DEF_TABLE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cke_pkg::cfg_t               cfg,
  input  logic                        q_not_empty,
  input  cke_pkg::q_entry_t           head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cke_pkg::KEY_W-1:0]   reduced_key,
  output logic [cke_pkg::HALF_W-1:0]  component,
  output logic [cke_pkg::HALF_W-1:0]  key_id
);
  import cke_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int TUP_W = 4 * MAX_HALF_SUBK;

  logic [TVAL_W-1:0] shuffle_mem [TABLE_DEPTH];
  logic [TVAL_W-1:0] rdata;

  logic adv;

  // lookup stage
  logic [WIN_W-1:0] canon;
  logic [HK_W-1:0]  sk, outlen;
  logic [TUP_W-1:0] tup_mask, tup;
  logic [IDX_W-1:0] raddr, waddr;
  logic             write_ok;

  // stage registers
  logic             s1_valid, s2_valid, s3_valid;
  logic [WIN_W-1:0] s1_canon;
  logic [HK_W-1:0]  s1_hk, s1_sk;
  logic [KEY_W-1:0] s2_packed, s3_key;
  logic [RL_W-1:0]  s2_rl;
  logic [TVAL_W-1:0] s2_pf;

  // filter and pack
  logic             keep;
  logic [WIN_W-1:0] lo_mask, outer_hi, outer_lo;
  logic [HK_W-1:0]  s1_outlen;
  logic [6:0]       red_shift;
  logic [KEY_W-1:0] shifted;
  logic [HALF_W-1:0] comp_next;

  assign adv = !out_valid || !out_stall;
  assign pop = adv && q_not_empty;

  always_comb begin
    canon = (head.fwd < head.rev) ? head.fwd : head.rev;
    if (cfg.half_subk == '0) begin
      sk = HK_W'(1);
    end else if (HK_W'(cfg.half_subk) > HK_W'(MAX_HALF_SUBK)) begin
      sk = HK_W'(MAX_HALF_SUBK);
    end else begin
      sk = HK_W'(cfg.half_subk);
    end
    if (sk > head.hk) begin
      sk = head.hk;
    end
    outlen = head.hk - sk;
    for (int i = 0; i < TUP_W; i++) begin
      tup_mask[i] = 7'(i) < {sk, 2'b00};
    end
    tup      = TUP_W'(canon >> {outlen, 1'b0}) & tup_mask;
    raddr    = IDX_W'(tup);
    waddr    = IDX_W'(head.tidx);
    write_ok = 32'(head.tidx) < 32'(TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (pop && head.is_write && write_ok) begin
      shuffle_mem[waddr] <= head.tval;
    end
    if (adv) begin
      rdata <= shuffle_mem[raddr];
    end
  end

  always_comb begin
    keep      = {1'b0, rdata} >= cfg.dim_floor && {1'b0, rdata} < cfg.dim_end;
    s1_outlen = s1_hk - s1_sk;
    for (int i = 0; i < WIN_W; i++) begin
      lo_mask[i] = 7'(i) < {1'b0, s1_outlen, 1'b0};
    end
    outer_hi  = s1_canon & (lo_mask << {s1_hk + s1_sk, 1'b0});
    outer_lo  = (s1_canon & lo_mask) << {s1_sk, 2'b00};
    red_shift = {s2_rl, 2'b00};
    shifted   = red_shift[6] ? '0 : (s2_packed >> red_shift[5:0]);
    for (int i = 0; i < HALF_W; i++) begin
      comp_next[i] = s3_key[i] && (CB_W'(i) < cfg.component_bits);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_canon    <= canon;
      s1_hk       <= head.hk;
      s1_sk       <= sk;
      s2_packed   <= outer_hi | outer_lo;
      s2_pf       <= rdata - TVAL_W'(cfg.dim_floor);
      s2_rl       <= cfg.reduce_level;
      s3_key      <= shifted + KEY_W'(s2_pf);
      reduced_key <= s3_key;
      component   <= comp_next;
      key_id      <= HALF_W'(s3_key >> cfg.component_bits);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= pop && !head.is_write;
      s2_valid  <= s1_valid && keep;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

endmodule

// ===== rtl/core/canonical_kmer_sketch_extractor.sv =====
// top level of the canonical k-mer sketch extractor
// Takes one item per clock while the queue has room: a sequence byte or a shuffle table
// write. The front end shifts each passing base into the forward and reverse-complement
// windows as it is taken, which sets the one-byte-per-cycle rate; the back end pops one
// queued entry (a table write or a full k-mer) whenever its output is not held. A k-mer
// passing the dimension filter goes through the queue and the lookup, packing and output
// registers. A four-entry queue separates the two halves, so the input keeps flowing while
// a finished result waits, until four table writes or k-mers are queued. The shuffle table
// depth must be a power of two; entries never written read back as unknown values.
module canonical_kmer_sketch_extractor #(
  parameter int MAX_HALF_SUBK = cke_pkg::DEF_MAX_HALF_SUBK,
  parameter int TABLE_DEPTH   = cke_pkg::DEF_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [cke_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cke_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            action,
  input  logic [cke_pkg::BYTE_W-1:0]      seq_byte,
  input  logic [cke_pkg::QUAL_W-1:0]      quality,
  input  logic                            read_start,
  input  logic [cke_pkg::TIDX_W-1:0]      table_index,
  input  logic [cke_pkg::TVAL_W-1:0]      table_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cke_pkg::KEY_W-1:0]       reduced_key,
  output logic [cke_pkg::HALF_W-1:0]      component,
  output logic [cke_pkg::HALF_W-1:0]      key_id
);
  import cke_pkg::*;

  cfg_t     cfg;
  logic     push, q_full, q_not_empty, pop;
  q_entry_t push_entry, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HALF_K:         cfg.half_k         <= cfg_data[HK_W-1:0];
        REG_HALF_SUBK:      cfg.half_subk      <= cfg_data[SUBK_W-1:0];
        REG_REDUCE_LEVEL:   cfg.reduce_level   <= cfg_data[RL_W-1:0];
        REG_DIM_FLOOR:      cfg.dim_floor      <= cfg_data[DIM_W-1:0];
        REG_DIM_END:        cfg.dim_end        <= cfg_data[DIM_W-1:0];
        REG_MIN_QUALITY:    cfg.min_quality    <= cfg_data[QUAL_W-1:0];
        REG_COMPONENT_BITS: cfg.component_bits <= cfg_data[CB_W-1:0];
        default: ;
      endcase
    end
  end

  cke_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .seq_byte    (seq_byte),
    .quality     (quality),
    .read_start  (read_start),
    .table_index (table_index),
    .table_value (table_value),
    .q_full      (q_full),
    .push        (push),
    .entry       (push_entry)
  );

  cke_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  cke_back #(
    .MAX_HALF_SUBK (MAX_HALF_SUBK),
    .TABLE_DEPTH   (TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reduced_key (reduced_key),
    .component   (component),
    .key_id      (key_id)
  );

endmodule

// ===== tb/testbench.sv =====
// testbench for the canonical k-mer sketch extractor, checked against a built-in key predictor
`timescale 1ns / 100ps

module testbench;
  import cke_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int DRAIN_WAIT  = 16;
  localparam int DRAIN_LIMIT = 5000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 85;
  localparam int PRELOAD     = 256;
  localparam int REPORT_MAX  = 10;

  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_TABLE = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [HALF_W-1:0] comp;
    logic [HALF_W-1:0] id;
  } kmer_key_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  action;
  logic [BYTE_W-1:0]     seq_byte;
  logic [QUAL_W-1:0]     quality;
  logic                  read_start;
  logic [TIDX_W-1:0]     table_index;
  logic [TVAL_W-1:0]     table_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [KEY_W-1:0]      reduced_key;
  logic [HALF_W-1:0]     component;
  logic [HALF_W-1:0]     key_id;

  canonical_kmer_sketch_extractor dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .seq_byte    (seq_byte),
    .quality     (quality),
    .read_start  (read_start),
    .table_index (table_index),
    .table_value (table_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reduced_key (reduced_key),
    .component   (component),
    .key_id      (key_id)
  );

  // predictor state
  logic [WIN_W-1:0]  fwd_win = '0;
  logic [WIN_W-1:0]  rev_win = '0;
  int                run_len = 1;
  bit                in_hdr = 1'b0;
  logic [TVAL_W-1:0] shuffle_mem [DEF_TABLE_DEPTH];
  bit                written [DEF_TABLE_DEPTH];
  cfg_t              cfg_now = CFG_RESET;
  kmer_key_t         expected_keys [$];

  bit quiet = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int table_writes = 0;
  int keys_checked = 0;
  int setting_count = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d keys still pending", cycle_count,
               expected_keys.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] exp,
                                 input logic [63:0] act);
    errors++;
    if (errors <= REPORT_MAX)
      $display("mismatch %0d: %s expected %h got %h", errors, what, exp, act);
  endtask

  function automatic int decode_base(input logic [BYTE_W-1:0] ch);
    case (ch)
      "A", "a": return 0;
      "C", "c": return 1;
      "G", "g": return 2;
      "T", "t": return 3;
      default:  return -1;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] base_char(input int code, input bit lower);
    logic [BYTE_W-1:0] ch;
    case (code)
      0:       ch = "A";
      1:       ch = "C";
      2:       ch = "G";
      default: ch = "T";
    endcase
    return lower ? (ch | 8'h20) : ch;
  endfunction

  // shuffle index that this byte would look up, if it completes a k-mer
  function automatic bit lookup_index(input logic [BYTE_W-1:0] ch, input logic [QUAL_W-1:0] q,
                                      input logic rs, output int idx);
    int          hk;
    int          sk;
    int          code;
    int          run;
    logic [63:0] mask;
    logic [63:0] b;
    logic [63:0] f;
    logic [63:0] r;
    logic [63:0] canon;
    idx = 0;
    if (in_hdr || ch == CH_LF || ch == CH_CR || ch == CH_HEADER) return 1'b0;
    code = decode_base(ch);
    if (code < 0 || q < cfg_now.min_quality) return 1'b0;
    hk = cfg_now.half_k;
    if (hk < 1) hk = 1;
    if (hk > MAX_HALF_K) hk = MAX_HALF_K;
    run = rs ? 1 : run_len;
    if (run < int'(RUN_MAX)) run++;
    if (run <= 2 * hk) return 1'b0;
    mask = {64{1'b1}} >> (64 - 4 * hk);
    b = 64'(code);
    f = ((fwd_win << 2) | b) & mask;
    r = ((rev_win >> 2) + ((b ^ 64'd3) << (4 * hk - 2))) & mask;
    sk = cfg_now.half_subk;
    if (sk < 1) sk = 1;
    if (sk > DEF_MAX_HALF_SUBK) sk = DEF_MAX_HALF_SUBK;
    if (sk > hk) sk = hk;
    canon = (f < r) ? f : r;
    idx = int'(((canon >> (2 * (hk - sk))) & ((64'd1 << (4 * sk)) - 64'd1)) % DEF_TABLE_DEPTH);
    return 1'b1;
  endfunction

  // filter and repack the canonical k-mer, queue the key if it survives
  task automatic reduce_kmer(input int hk);
    int          sk;
    int          outlen;
    int          shift;
    logic [63:0] canon;
    logic [63:0] tup;
    logic [63:0] pf;
    logic [63:0] low_mask;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] key;
    logic [63:0] comp_full;
    logic [63:0] id_full;
    kmer_key_t   r;
    sk = cfg_now.half_subk;
    if (sk < 1) sk = 1;
    if (sk > DEF_MAX_HALF_SUBK) sk = DEF_MAX_HALF_SUBK;
    if (sk > hk) sk = hk;
    outlen = hk - sk;
    canon = (fwd_win < rev_win) ? fwd_win : rev_win;
    tup = (canon >> (2 * outlen)) & ((64'd1 << (4 * sk)) - 64'd1);
    pf = 64'(shuffle_mem[tup % DEF_TABLE_DEPTH]);
    if (pf >= 64'(cfg_now.dim_end) || pf < 64'(cfg_now.dim_floor)) return;
    pf = pf - 64'(cfg_now.dim_floor);
    low_mask = (64'd1 << (2 * outlen)) - 64'd1;
    hi = canon & (low_mask << (2 * (hk + sk)));
    lo = (canon & low_mask) << (4 * sk);
    shift = 4 * int'(cfg_now.reduce_level);
    key = (shift >= 64) ? 64'd0 : ((hi + lo) >> shift);
    key = key + pf;
    comp_full = (cfg_now.component_bits == 0) ? 64'd0
              : (key & ((64'd1 << cfg_now.component_bits) - 64'd1));
    id_full = key >> cfg_now.component_bits;
    r.key = key;
    r.comp = comp_full[HALF_W-1:0];
    r.id = id_full[HALF_W-1:0];
    expected_keys.push_back(r);
  endtask

  task automatic predict_item(input logic act, input logic [BYTE_W-1:0] ch,
                              input logic [QUAL_W-1:0] q, input logic rs,
                              input logic [TIDX_W-1:0] tidx, input logic [TVAL_W-1:0] tval);
    int          hk;
    int          code;
    logic [63:0] mask;
    logic [63:0] b;
    if (act == ACT_TABLE) begin
      shuffle_mem[tidx] = tval;
      written[tidx] = 1'b1;
      table_writes++;
      return;
    end
    if (rs) run_len = 1;
    if (in_hdr) begin
      if (ch == CH_LF) in_hdr = 1'b0;
      return;
    end
    if (ch == CH_LF || ch == CH_CR) return;
    if (ch == CH_HEADER) begin
      in_hdr = 1'b1;
      run_len = 1;
      return;
    end
    code = decode_base(ch);
    if (code < 0 || q < cfg_now.min_quality) begin
      run_len = 1;
      return;
    end
    hk = cfg_now.half_k;
    if (hk < 1) hk = 1;
    if (hk > MAX_HALF_K) hk = MAX_HALF_K;
    mask = {64{1'b1}} >> (64 - 4 * hk);
    b = 64'(code);
    fwd_win = ((fwd_win << 2) | b) & mask;
    rev_win = ((rev_win >> 2) + ((b ^ 64'd3) << (4 * hk - 2))) & mask;
    if (run_len < int'(RUN_MAX)) run_len++;
    if (run_len > 2 * hk) reduce_kmer(hk);
  endtask

  task automatic send_item(input logic act, input logic [BYTE_W-1:0] ch,
                           input logic [QUAL_W-1:0] q, input logic rs,
                           input logic [TIDX_W-1:0] tidx, input logic [TVAL_W-1:0] tval);
    logic stalled;
    if (!quiet && $urandom_range(0, 15) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    seq_byte    <= ch;
    quality     <= q;
    read_start  <= rs;
    table_index <= tidx;
    table_value <= tval;
    do begin
      @(negedge clk);
      stalled = (in_stall !== 1'b0);
      @(posedge clk);
    end while (stalled);
    predict_item(act, ch, q, rs, tidx, tval);
    items_sent++;
  endtask

  task automatic send_table(input logic [TIDX_W-1:0] tidx, input logic [TVAL_W-1:0] tval);
    send_item(ACT_TABLE, BYTE_W'($urandom), QUAL_W'($urandom), 1'($urandom), tidx, tval);
  endtask

  // a shuffle entry is always written before the first k-mer that looks it up
  task automatic send_byte(input logic [BYTE_W-1:0] ch, input logic [QUAL_W-1:0] q,
                           input logic rs);
    int idx;
    if (lookup_index(ch, q, rs, idx) && !written[idx])
      send_table(TIDX_W'(idx), TVAL_W'($urandom));
    send_item(ACT_BYTE, ch, q, rs, TIDX_W'($urandom), TVAL_W'($urandom));
  endtask

  // stop sending, let every queued key arrive, then let filtered k-mers leave the pipe
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_keys.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_keys.size() != 0) begin
      report_mismatch("keys never delivered", 64'(expected_keys.size()), 64'd0);
      errors += expected_keys.size() - 1;
      expected_keys.delete();
    end
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(REG_HALF_K, CFG_DATA_W'(c.half_k));
    write_reg(REG_HALF_SUBK, CFG_DATA_W'(c.half_subk));
    write_reg(REG_REDUCE_LEVEL, CFG_DATA_W'(c.reduce_level));
    write_reg(REG_DIM_FLOOR, CFG_DATA_W'(c.dim_floor));
    write_reg(REG_DIM_END, CFG_DATA_W'(c.dim_end));
    write_reg(REG_MIN_QUALITY, CFG_DATA_W'(c.min_quality));
    write_reg(REG_COMPONENT_BITS, CFG_DATA_W'(c.component_bits));
    cfg_write <= 1'b0;
    cfg_now = c;
    setting_count++;
  endtask

  function automatic cfg_t make_cfg(input int hk, input int sk, input int rl, input int ds,
                                    input int de, input int mq, input int cb);
    cfg_t c;
    c.half_k         = HK_W'(hk);
    c.half_subk      = SUBK_W'(sk);
    c.reduce_level   = RL_W'(rl);
    c.dim_floor      = DIM_W'(ds);
    c.dim_end        = DIM_W'(de);
    c.min_quality    = QUAL_W'(mq);
    c.component_bits = CB_W'(cb);
    return c;
  endfunction

  function automatic logic [QUAL_W-1:0] pass_quality();
    if ($urandom_range(0, 99) == 0) return QUAL_W'($urandom);
    return QUAL_W'($urandom_range(int'(cfg_now.min_quality), 255));
  endfunction

  // mostly long base runs; headers, line breaks, junk and table writes mixed in
  task automatic random_stream(input int count);
    int made;
    int r;
    int n;
    logic [BYTE_W-1:0] ch;
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 999);
      if (r < 930) begin
        send_byte(base_char($urandom_range(0, 3), 1'($urandom)), pass_quality(), 1'b0);
        made++;
      end else if (r < 950) begin
        send_byte($urandom_range(0, 1) ? CH_LF : CH_CR, QUAL_W'($urandom), 1'b0);
      end else if (r < 960) begin
        send_byte(CH_HEADER, QUAL_W'($urandom), 1'b0);
        n = $urandom_range(0, 6);
        repeat (n) begin
          ch = BYTE_W'($urandom);
          if (ch == CH_LF) ch = CH_HEADER;
          send_byte(ch, QUAL_W'($urandom), 1'($urandom));
        end
        send_byte(CH_LF, QUAL_W'($urandom), 1'b0);
        made++;
      end else if (r < 975) begin
        send_byte(BYTE_W'($urandom), QUAL_W'($urandom), 1'($urandom));
        made++;
      end else if (r < 990) begin
        send_table(TIDX_W'($urandom), TVAL_W'($urandom));
        made++;
      end else begin
        send_byte(base_char($urandom_range(0, 3), 1'($urandom)), pass_quality(), 1'b1);
        made++;
      end
    end
  endtask

  // the low shuffle entries and the top one up front; the rest on first use
  task automatic test_table_load();
    for (int i = 0; i < PRELOAD; i++) begin
      if (i == 0)
        send_table(TIDX_W'(i), '0);
      else
        send_table(TIDX_W'(i), TVAL_W'($urandom));
    end
    send_table(TIDX_W'(DEF_TABLE_DEPTH - 1), '1);
    wait_idle();
  endtask

  task automatic test_directed();
    load_config(make_cfg(1, 1, 0, 0, 4096, 20, 4));
    send_byte("A", 8'd255, 1'b0);
    send_byte("c", 8'd20, 1'b0);
    send_byte("G", 8'd19, 1'b0);
    send_byte("g", 8'd200, 1'b0);
    send_byte("t", 8'd20, 1'b0);
    send_byte("T", 8'd100, 1'b1);
    send_byte("a", 8'd100, 1'b0);
    send_table('0, '1);
    send_byte("C", 8'd100, 1'b0);
    send_byte(CH_LF, 8'd0, 1'b0);
    send_byte(CH_CR, 8'd0, 1'b0);
    send_byte("g", 8'd100, 1'b0);
    send_byte(CH_HEADER, 8'd100, 1'b0);
    send_byte("A", 8'd100, 1'b1);
    send_byte(CH_CR, 8'd100, 1'b0);
    send_byte(CH_HEADER, 8'd100, 1'b0);
    send_byte(CH_LF, 8'd100, 1'b0);
    send_byte("T", 8'd100, 1'b0);
    send_byte("N", 8'd100, 1'b0);
    send_byte("A", 8'd100, 1'b0);
    send_byte("C", 8'd100, 1'b0);
    send_byte(8'hff, 8'd255, 1'b0);
    send_byte(8'h00, 8'd255, 1'b0);
    send_table('1, '0);
    send_byte("t", 8'd255, 1'b0);
    send_byte("G", 8'd255, 1'b0);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    cfg_t plan [7];
    plan[0] = CFG_RESET;
    plan[1] = make_cfg(16, 3, 0, 0, 4096, 0, 63);
    plan[2] = make_cfg(0, 0, 31, 0, 4096, 255, 32);
    plan[3] = make_cfg(31, 2, 16, 4096, 4096, 0, 1);
    plan[4] = make_cfg(2, 3, 15, 0, 0, 128, 0);
    plan[5] = make_cfg(5, 1, 1, 1000, 3000, 40, 20);
    plan[6] = make_cfg(8, 2, 8, 0, 4096, 0, 31);
    foreach (plan[i]) begin
      load_config(plan[i]);
      random_stream(PHASE_ITEMS);
      wait_idle();
    end
  endtask

  task automatic test_random_settings();
    int ds;
    repeat (8) begin
      ds = $urandom_range(0, 2048);
      load_config(make_cfg($urandom_range(1, 16), $urandom_range(1, 3), $urandom_range(0, 16),
                           ds, $urandom_range(ds, 4096), $urandom_range(0, 255),
                           $urandom_range(0, 63)));
      random_stream(PHASE_ITEMS);
      wait_idle();
    end
  endtask

  // full-rate streaming with neither side holding off
  task automatic test_no_idle();
    quiet = 1'b1;
    load_config(make_cfg(4, 2, 0, 0, 4096, 10, 12));
    random_stream(150);
    wait_idle();
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(0, 30)) @(posedge clk);
      end
    end
  end

  always @(negedge clk) begin
    kmer_key_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      keys_checked++;
      if (expected_keys.size() == 0) begin
        report_mismatch("key with none pending", 64'd0, reduced_key);
      end else begin
        want = expected_keys.pop_front();
        if (reduced_key !== want.key) report_mismatch("reduced_key", want.key, reduced_key);
        if (component !== want.comp) report_mismatch("component", 64'(want.comp), 64'(component));
        if (key_id !== want.id) report_mismatch("key_id", 64'(want.id), 64'(key_id));
      end
    end
  end

  initial begin
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_index   <= REG_HALF_K;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    action      <= ACT_BYTE;
    seq_byte    <= '0;
    quality     <= '0;
    read_start  <= 1'b0;
    table_index <= '0;
    table_value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_table_load();
    test_directed();
    test_config_extremes();
    test_random_settings();
    test_no_idle();

    $display("sent %0d items (%0d table writes) under %0d register settings",
             items_sent, table_writes, setting_count);
    $display("compared %0d keys, %0d mismatches", keys_checked, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
